// ===== src/rprq_pkg.sv =====
// Shared constants, types and helpers of the retransmit queue.
package rprq_pkg;

  localparam int RING_SLOTS       = 16;
  localparam int SLOT_W           = $clog2(RING_SLOTS);
  localparam int MAX_PACKET_BYTES = 4096;
  localparam int HDR_BYTES        = 16;

  localparam int TPS_W     = 10;
  localparam int LIMIT_W   = 8;
  localparam int COOKIE_W  = 64;
  localparam int SEQ_W     = 32;
  localparam int TS_W      = 32;
  localparam int FRAME_W   = 32;
  localparam int BACKOFF_W = 18;
  localparam int PEND_W    = 12;
  localparam int LEN_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [TPS_W-1:0]   TPS_RESET   = TPS_W'(10);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(120);
  localparam logic [PEND_W-1:0]  LEN_CAP     = PEND_W'(MAX_PACKET_BYTES - HDR_BYTES);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_LIMIT    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SESSION_COOKIE   = CFG_IDX_W'(2);

  // Input beat kinds.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ACK  = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [TS_W-1:0]     ts;
    logic [COOKIE_W-1:0] cookie;
    logic [LEN_W-1:0]    len;
  } slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic rd;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } status_t;

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] i);
    ring_next = (i == SLOT_W'(RING_SLOTS - 1)) ? '0 : i + SLOT_W'(1);
  endfunction

endpackage

// ===== src/reliable_packet_retransmit_queue.sv =====
// Top level of the retransmit queue: controller plus datapath.
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall  | one tick or one acknowledgement
//   out_    | output    | out_valid/out_stall| one result per input beat
//   cfg_    | input     | cfg_we             | one register write
//
// An input beat goes through capture, ring update and slot write, the registered
// read of the oldest slot, then the send or ack decision.
// The synchronous ring memory read sets the read cycle.
// Reset is synchronous and active low and clears pointers and counters; the ring
// contents are not cleared.
// The result sits in an output register; a stalled result holds the next beat
// in its final cycle only.
module reliable_packet_retransmit_queue (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rprq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rprq_pkg::COOKIE_W-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic [rprq_pkg::PEND_W-1:0]          in_pending_length,
  input  logic [rprq_pkg::TS_W-1:0]            in_timestamp_now,
  input  logic                                 in_address_known,
  input  logic                                 in_ack_from_server,
  input  logic [rprq_pkg::SEQ_W-1:0]           in_ack_sequence,
  input  logic [rprq_pkg::TS_W-1:0]            in_ack_timestamp,
  input  logic [rprq_pkg::COOKIE_W-1:0]        in_ack_cookie,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_stored,
  output logic [rprq_pkg::SLOT_W-1:0]          out_store_slot,
  output logic                                 out_dropped_oldest,
  output logic                                 out_send,
  output logic [rprq_pkg::SLOT_W-1:0]          out_send_slot,
  output logic [rprq_pkg::SEQ_W-1:0]           out_send_sequence,
  output logic [rprq_pkg::TS_W-1:0]            out_send_timestamp,
  output logic [rprq_pkg::LEN_W-1:0]           out_send_length,
  output logic                                 out_ack_accepted
);
  import rprq_pkg::*;

  cmd_t    cmd;
  status_t status;

  rprq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rprq_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_cmd             (in_cmd),
    .in_pending_length  (in_pending_length),
    .in_timestamp_now   (in_timestamp_now),
    .in_address_known   (in_address_known),
    .in_ack_from_server (in_ack_from_server),
    .in_ack_sequence    (in_ack_sequence),
    .in_ack_timestamp   (in_ack_timestamp),
    .in_ack_cookie      (in_ack_cookie),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_stored         (out_stored),
    .out_store_slot     (out_store_slot),
    .out_dropped_oldest (out_dropped_oldest),
    .out_send           (out_send),
    .out_send_slot      (out_send_slot),
    .out_send_sequence  (out_send_sequence),
    .out_send_timestamp (out_send_timestamp),
    .out_send_length    (out_send_length),
    .out_ack_accepted   (out_ack_accepted)
  );

endmodule

// ===== src/rprq_ctrl.sv =====
// Sequencing state machine of the retransmit queue.
module rprq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rprq_pkg::status_t status,
  output rprq_pkg::cmd_t   cmd
);
  import rprq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_FIN;
      ST_FIN:  if (!status.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign cmd.capture = (state_r == ST_IDLE) && in_valid;
  assign cmd.exec    = (state_r == ST_EXEC);
  assign cmd.rd      = (state_r == ST_READ);
  // The result register may be refilled in the cycle its beat is taken.
  assign cmd.fin     = (state_r == ST_FIN) && !status.out_busy;

endmodule

// ===== src/rprq_dp.sv =====
// Ring storage, counters, backoff arithmetic and result register.
module rprq_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rprq_pkg::cmd_t                       cmd,
  output rprq_pkg::status_t                    status,
  input  logic                                 cfg_we,
  input  logic [rprq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rprq_pkg::COOKIE_W-1:0]        cfg_wdata,
  input  logic                                 in_cmd,
  input  logic [rprq_pkg::PEND_W-1:0]          in_pending_length,
  input  logic [rprq_pkg::TS_W-1:0]            in_timestamp_now,
  input  logic                                 in_address_known,
  input  logic                                 in_ack_from_server,
  input  logic [rprq_pkg::SEQ_W-1:0]           in_ack_sequence,
  input  logic [rprq_pkg::TS_W-1:0]            in_ack_timestamp,
  input  logic [rprq_pkg::COOKIE_W-1:0]        in_ack_cookie,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_stored,
  output logic [rprq_pkg::SLOT_W-1:0]          out_store_slot,
  output logic                                 out_dropped_oldest,
  output logic                                 out_send,
  output logic [rprq_pkg::SLOT_W-1:0]          out_send_slot,
  output logic [rprq_pkg::SEQ_W-1:0]           out_send_sequence,
  output logic [rprq_pkg::TS_W-1:0]            out_send_timestamp,
  output logic [rprq_pkg::LEN_W-1:0]           out_send_length,
  output logic                                 out_ack_accepted
);
  import rprq_pkg::*;

  // Configuration registers.
  logic [TPS_W-1:0]     tps_r;
  logic [LIMIT_W-1:0]   limit_sec_r;
  logic [COOKIE_W-1:0]  cookie_r;
  logic [BACKOFF_W-1:0] limit_ticks_r;

  // Captured input beat.
  logic                 cmd_r;
  logic [PEND_W-1:0]    pend_r;
  logic [TS_W-1:0]      now_r;
  logic                 addr_ok_r;
  logic                 from_srv_r;
  logic [SEQ_W-1:0]     a_seq_r;
  logic [TS_W-1:0]      a_ts_r;
  logic [COOKIE_W-1:0]  a_cookie_r;

  // Queue state.
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic [FRAME_W-1:0]   last_gen_r, last_gen_nxt;
  logic [SEQ_W-1:0]     seq_r, seq_nxt;
  logic [FRAME_W-1:0]   last_tx_r, last_tx_nxt;
  logic [BACKOFF_W-1:0] backoff_r, backoff_nxt;
  logic [SLOT_W-1:0]    head_r, head_nxt;
  logic [SLOT_W-1:0]    tail_r, tail_nxt;

  // Outcome of the generate step, held until the result is built.
  logic                 gen_stored_r, gen_stored_nxt;
  logic [SLOT_W-1:0]    gen_slot_r, gen_slot_nxt;
  logic                 gen_drop_r, gen_drop_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 o_stored_r, o_stored_nxt;
  logic [SLOT_W-1:0]    o_store_slot_r, o_store_slot_nxt;
  logic                 o_drop_r, o_drop_nxt;
  logic                 o_send_r, o_send_nxt;
  logic [SLOT_W-1:0]    o_send_slot_r, o_send_slot_nxt;
  logic [SEQ_W-1:0]     o_seq_r, o_seq_nxt;
  logic [TS_W-1:0]      o_ts_r, o_ts_nxt;
  logic [LEN_W-1:0]     o_len_r, o_len_nxt;
  logic                 o_ack_r, o_ack_nxt;

  slot_t                mem [RING_SLOTS];
  slot_t                rdata_r;
  slot_t                wr_slot;

  logic                 gen_ok;
  logic                 tx_ok;
  logic                 ack_ok;
  logic                 ring_empty;
  logic [PEND_W-1:0]    len_sat;
  logic [SLOT_W-1:0]    head_adv;
  logic [BACKOFF_W:0]   grown;
  logic [BACKOFF_W-1:0] backoff_grown;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= TPS_RESET;
      limit_sec_r <= LIMIT_RESET;
      cookie_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_SECOND: tps_r       <= cfg_wdata[TPS_W-1:0];
        CFG_BACKOFF_LIMIT:    limit_sec_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_SESSION_COOKIE:   cookie_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The backoff ceiling in ticks is a registered product of the two settings.
  always_ff @(posedge clk) begin
    limit_ticks_r <= BACKOFF_W'(limit_sec_r) * BACKOFF_W'(tps_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r      <= in_cmd;
      pend_r     <= in_pending_length;
      now_r      <= in_timestamp_now;
      addr_ok_r  <= in_address_known;
      from_srv_r <= in_ack_from_server;
      a_seq_r    <= in_ack_sequence;
      a_ts_r     <= in_ack_timestamp;
      a_cookie_r <= in_ack_cookie;
    end
  end

  assign len_sat    = (pend_r > LEN_CAP) ? LEN_CAP : pend_r;
  assign head_adv   = ring_next(head_r);
  assign ring_empty = (tail_r == head_r);

  assign gen_ok = (cmd_r == CMD_TICK) && (pend_r != '0) &&
                  ((frame_r - last_gen_r) >= FRAME_W'(tps_r));

  assign wr_slot.seq    = seq_r + SEQ_W'(1);
  assign wr_slot.ts     = now_r;
  assign wr_slot.cookie = cookie_r;
  assign wr_slot.len    = LEN_W'(len_sat) + LEN_W'(HDR_BYTES);

  assign tx_ok  = addr_ok_r && !ring_empty &&
                  ((frame_r - last_tx_r) >= FRAME_W'(backoff_r));
  assign ack_ok = from_srv_r && !ring_empty && (rdata_r.seq == a_seq_r) &&
                  (rdata_r.ts == a_ts_r) && (rdata_r.cookie == a_cookie_r);

  assign grown         = (BACKOFF_W+1)'(backoff_r) + (BACKOFF_W+1)'(tps_r);
  assign backoff_grown = (grown < (BACKOFF_W+1)'(limit_ticks_r)) ?
                         grown[BACKOFF_W-1:0] : limit_ticks_r;

  always_ff @(posedge clk) begin
    if (cmd.exec && gen_ok) begin
      mem[head_r] <= wr_slot;
    end
    if (cmd.rd) begin
      rdata_r <= mem[tail_r];
    end
  end

  always_comb begin
    frame_nxt        = frame_r;
    last_gen_nxt     = last_gen_r;
    seq_nxt          = seq_r;
    last_tx_nxt      = last_tx_r;
    backoff_nxt      = backoff_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    gen_stored_nxt   = gen_stored_r;
    gen_slot_nxt     = gen_slot_r;
    gen_drop_nxt     = gen_drop_r;
    out_valid_nxt    = out_valid_r && out_stall;
    o_stored_nxt     = o_stored_r;
    o_store_slot_nxt = o_store_slot_r;
    o_drop_nxt       = o_drop_r;
    o_send_nxt       = o_send_r;
    o_send_slot_nxt  = o_send_slot_r;
    o_seq_nxt        = o_seq_r;
    o_ts_nxt         = o_ts_r;
    o_len_nxt        = o_len_r;
    o_ack_nxt        = o_ack_r;

    if (cmd.exec) begin
      gen_stored_nxt = 1'b0;
      gen_slot_nxt   = '0;
      gen_drop_nxt   = 1'b0;
      if (gen_ok) begin
        last_gen_nxt   = frame_r;
        seq_nxt        = seq_r + SEQ_W'(1);
        head_nxt       = head_adv;
        gen_stored_nxt = 1'b1;
        gen_slot_nxt   = head_r;
        // Catching up with the tail means the ring is full: drop the oldest.
        if (head_adv == tail_r) begin
          tail_nxt     = ring_next(tail_r);
          gen_drop_nxt = 1'b1;
        end
      end
    end

    if (cmd.fin) begin
      out_valid_nxt    = 1'b1;
      o_stored_nxt     = 1'b0;
      o_store_slot_nxt = '0;
      o_drop_nxt       = 1'b0;
      o_send_nxt       = 1'b0;
      o_send_slot_nxt  = '0;
      o_seq_nxt        = '0;
      o_ts_nxt         = '0;
      o_len_nxt        = '0;
      o_ack_nxt        = 1'b0;
      if (cmd_r == CMD_ACK) begin
        if (ack_ok) begin
          tail_nxt    = ring_next(tail_r);
          backoff_nxt = BACKOFF_W'(tps_r);
          o_ack_nxt   = 1'b1;
        end
      end else begin
        o_stored_nxt     = gen_stored_r;
        o_store_slot_nxt = gen_slot_r;
        o_drop_nxt       = gen_drop_r;
        if (tx_ok) begin
          last_tx_nxt     = frame_r;
          backoff_nxt     = backoff_grown;
          o_send_nxt      = 1'b1;
          o_send_slot_nxt = tail_r;
          o_seq_nxt       = rdata_r.seq;
          o_ts_nxt        = rdata_r.ts;
          o_len_nxt       = rdata_r.len;
        end
        frame_nxt = frame_r + FRAME_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r      <= '0;
      last_gen_r   <= '0;
      seq_r        <= '0;
      last_tx_r    <= '0;
      backoff_r    <= BACKOFF_W'(TPS_RESET);
      head_r       <= '0;
      tail_r       <= '0;
      gen_stored_r <= 1'b0;
      gen_slot_r   <= '0;
      gen_drop_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      frame_r      <= frame_nxt;
      last_gen_r   <= last_gen_nxt;
      seq_r        <= seq_nxt;
      last_tx_r    <= last_tx_nxt;
      backoff_r    <= backoff_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      gen_stored_r <= gen_stored_nxt;
      gen_slot_r   <= gen_slot_nxt;
      gen_drop_r   <= gen_drop_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_stored_r     <= o_stored_nxt;
    o_store_slot_r <= o_store_slot_nxt;
    o_drop_r       <= o_drop_nxt;
    o_send_r       <= o_send_nxt;
    o_send_slot_r  <= o_send_slot_nxt;
    o_seq_r        <= o_seq_nxt;
    o_ts_r         <= o_ts_nxt;
    o_len_r        <= o_len_nxt;
    o_ack_r        <= o_ack_nxt;
  end

  assign status.out_busy    = out_valid_r && out_stall;
  assign out_valid          = out_valid_r;
  assign out_stored         = o_stored_r;
  assign out_store_slot     = o_store_slot_r;
  assign out_dropped_oldest = o_drop_r;
  assign out_send           = o_send_r;
  assign out_send_slot      = o_send_slot_r;
  assign out_send_sequence  = o_seq_r;
  assign out_send_timestamp = o_ts_r;
  assign out_send_length    = o_len_r;
  assign out_ack_accepted   = o_ack_r;

endmodule
